// File: hw/rtl/aema_pkg.sv
`timescale 1ns / 1ps

package aema_pkg;

	// field widths
	localparam int unsigned SLOT_W   = 11;
	localparam int unsigned ALPHA_W  = 17;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned LOAD_W   = 24;
	localparam int unsigned LOSS_W   = 17;
	localparam int unsigned CFG_W    = 17;
	localparam int unsigned CFG_IDX_W = 2;

	// quotient bits produced by each serial divider
	localparam int unsigned QUO_W = 24;
	localparam int unsigned CNT_W = 5;

	localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'd65536;
	localparam logic [LOAD_W-1:0]  LOAD_MAX = 24'hFFFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOSS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLL_WEIGHT = 2'd2;

	// request codes
	localparam logic REQ_REPORT  = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] total_slots;
		logic [SLOT_W-1:0] success_slots;
		logic [SLOT_W-1:0] collision_slots;
	} in_word_t;

	typedef struct packed {
		logic [LOAD_W-1:0] load_estimate;
		logic [LOSS_W-1:0] loss_estimate;
		logic              estimate_valid;
	} out_word_t;

	// control of a serial unit: load operands, advance one digit
	typedef struct packed {
		logic load;
		logic step;
	} step_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EMA_START,
		ST_EMA,
		ST_UPDATE,
		ST_RESULT
	} state_t;

endpackage

// File: hw/rtl/aema_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per step. The starting remainder must be
// below the divisor; the low dividend bits shift out as quotient bits shift in.
module aema_div import aema_pkg::*; #(
	parameter int unsigned DW = 11
) (
	input  logic             clk,
	input  step_ctl_t        ctl,
	input  logic [DW-1:0]    rem_init,
	input  logic [QUO_W-1:0] low,
	input  logic [DW-1:0]    divisor,
	output logic [QUO_W-1:0] quo
);

	logic [DW-1:0]    rem_q;
	logic [QUO_W-1:0] lq_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             ge;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, lq_q[QUO_W-1]};
		diff  = trial - {1'b0, divisor};
		ge    = (trial >= {1'b0, divisor});
	end

	// load operands or advance one quotient bit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= rem_init;
			lq_q  <= low;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			lq_q  <= {lq_q[QUO_W-2:0], ge};
		end
	end

	assign quo = lq_q;

endmodule

// File: hw/rtl/aema_ema.sv
`timescale 1ns / 1ps

// Moving average update old*65536 + alpha*(inst-old), rounded and scaled
// back by 2^16. Alpha is taken one bit per step, LSB first.
module aema_ema import aema_pkg::*; #(
	parameter int unsigned W = 24
) (
	input  logic               clk,
	input  step_ctl_t          ctl,
	input  logic [ALPHA_W-1:0] alpha,
	input  logic [W-1:0]       inst,
	input  logic [W-1:0]       old,
	output logic [W-1:0]       result
);

	localparam int unsigned AW = W + 18;

	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] mcand_q;
	logic [ALPHA_W-1:0]   mult_q;
	logic [W:0]           delta;
	logic [AW-1:0]        rounded;

	assign delta = {1'b0, inst} - {1'b0, old};

	// load operands or add one shifted partial product
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q   <= $signed({2'b00, old, 16'b0});
			mcand_q <= $signed({{17{delta[W]}}, delta});
			mult_q  <= alpha;
		end else if (ctl.step) begin
			if (mult_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q <<< 1;
			mult_q  <= mult_q >> 1;
		end
	end

	// round half up and drop the fraction
	assign rounded = acc_q + {{(AW-16){1'b0}}, 1'b1, 15'b0};
	assign result  = rounded[W+15:16];

endmodule

// File: hw/rtl/aloha_load_ema_estimator.sv
`timescale 1ns / 1ps

// channel  | handshake               | word
// ---------+-------------------------+--------------------------------------
// in       | in_valid / in_stall     | in_word  : req_type, slot counts
// out      | out_valid / out_stall   | out_word : load, loss, estimate_valid
// cfg      | cfg_write               | cfg_index, cfg_data
//
// A frame report passes from accept to the result register through prepare, the
// 24 quotient bits of both serial dividers, operand load, the 17 alpha bits of both
// averaging units, update and issue. Restart and empty frames go from prepare to issue.
// The next word is taken in the cycle after issue.
// Reset clears both averages and arms seeding; registers take their defaults.
// Issue stalls only while the previous result still waits in the output register.
module aloha_load_ema_estimator import aema_pkg::*; #(
	parameter int unsigned MAX_SLOTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [15:0] MAX_CNT = 16'(MAX_SLOTS);
	localparam int unsigned ATT_W = SLOT_W + 1;

	state_t state_q, state_d;

	logic [ALPHA_W-1:0]  alpha_load_q, alpha_loss_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic              req_q;
	logic [SLOT_W-1:0] total_q, succ_q, coll_q;
	logic              sat_q, att_zero_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic [LOAD_W-1:0] smoothed_load_q;
	logic [LOSS_W-1:0] smoothed_loss_q;
	logic              awaiting_first_q;

	logic      out_valid_q;
	out_word_t out_word_q;

	step_ctl_t div_ctl, ema_ctl;
	logic      in_take, out_load, sm_clear, sm_update, prep_div;

	logic [SLOT_W-1:0] total_c, succ_c, coll_c;
	logic [27:0]       num;
	logic [35:0]       load_dvd;
	logic [ATT_W-1:0]  att;
	logic [27:0]       loss_dvd;
	logic              load_sat;
	logic [QUO_W-1:0]  load_quo, loss_quo;
	logic [LOAD_W-1:0] inst_load, ema_load;
	logic [LOSS_W-1:0] inst_loss, ema_loss;
	logic [ALPHA_W-1:0] eff_alpha_load, eff_alpha_loss;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// clamp oversized slot counts
	always_comb begin
		total_c = ({5'b0, in_word.total_slots} > MAX_CNT) ? MAX_CNT[SLOT_W-1:0]
			: in_word.total_slots;
		succ_c  = ({5'b0, in_word.success_slots} > MAX_CNT) ? MAX_CNT[SLOT_W-1:0]
			: in_word.success_slots;
		coll_c  = ({5'b0, in_word.collision_slots} > MAX_CNT) ? MAX_CNT[SLOT_W-1:0]
			: in_word.collision_slots;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_load_q <= 17'd6554;
			alpha_loss_q <= 17'd6554;
			weight_q     <= 16'd256;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ALPHA_LOAD:  alpha_load_q <= cfg_data;
				REG_ALPHA_LOSS:  alpha_loss_q <= cfg_data;
				REG_COLL_WEIGHT: weight_q     <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q   <= in_word.req_type;
			total_q <= total_c;
			succ_q  <= succ_c;
			coll_q  <= coll_c;
		end
	end

	// form rounded dividends for the instant load and loss
	always_comb begin
		num      = {9'b0, succ_q, 8'b0} + ({17'b0, coll_q} * {12'b0, weight_q});
		load_dvd = {num, 8'b0} + {26'b0, total_q[SLOT_W-1:1]};
		load_sat = (load_dvd[35:24] >= {1'b0, total_q});
		att      = {1'b0, succ_q} + {1'b0, coll_q};
		loss_dvd = {1'b0, coll_q, 16'b0} + {17'b0, att[ATT_W-1:1]};
	end

	always_ff @(posedge clk) begin
		if (prep_div) begin
			sat_q      <= load_sat;
			att_zero_q <= (att == '0);
		end
	end

	aema_div #(.DW(SLOT_W)) u_div_load (
		.clk      (clk),
		.ctl      (div_ctl),
		.rem_init (load_dvd[34:24]),
		.low      (load_dvd[QUO_W-1:0]),
		.divisor  (total_q),
		.quo      (load_quo)
	);

	aema_div #(.DW(ATT_W)) u_div_loss (
		.clk      (clk),
		.ctl      (div_ctl),
		.rem_init ({8'b0, loss_dvd[27:24]}),
		.low      (loss_dvd[QUO_W-1:0]),
		.divisor  (att),
		.quo      (loss_quo)
	);

	// saturate load, zero loss without attempts; seed with alpha of one
	always_comb begin
		inst_load      = sat_q ? LOAD_MAX : load_quo;
		inst_loss      = att_zero_q ? '0 : loss_quo[LOSS_W-1:0];
		eff_alpha_load = (awaiting_first_q || alpha_load_q[16]) ? ONE_Q16 : alpha_load_q;
		eff_alpha_loss = (awaiting_first_q || alpha_loss_q[16]) ? ONE_Q16 : alpha_loss_q;
	end

	aema_ema #(.W(LOAD_W)) u_ema_load (
		.clk    (clk),
		.ctl    (ema_ctl),
		.alpha  (eff_alpha_load),
		.inst   (inst_load),
		.old    (smoothed_load_q),
		.result (ema_load)
	);

	aema_ema #(.W(LOSS_W)) u_ema_loss (
		.clk    (clk),
		.ctl    (ema_ctl),
		.alpha  (eff_alpha_loss),
		.inst   (inst_loss),
		.old    (smoothed_loss_q),
		.result (ema_loss)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and unit controls
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		div_ctl   = '0;
		ema_ctl   = '0;
		sm_clear  = 1'b0;
		sm_update = 1'b0;
		out_load  = 1'b0;
		prep_div  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				priority if (req_q == REQ_RESTART) begin
					sm_clear = 1'b1;
					state_d  = ST_RESULT;
				end else if (total_q == '0) begin
					state_d = ST_RESULT;
				end else begin
					prep_div     = 1'b1;
					div_ctl.load = 1'b1;
					cnt_d        = CNT_W'(QUO_W - 1);
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_EMA_START;
				end
			end
			ST_EMA_START: begin
				ema_ctl.load = 1'b1;
				cnt_d        = CNT_W'(ALPHA_W - 1);
				state_d      = ST_EMA;
			end
			ST_EMA: begin
				ema_ctl.step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				sm_update = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// averages and seeding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_load_q  <= '0;
			smoothed_loss_q  <= '0;
			awaiting_first_q <= 1'b1;
		end else if (sm_clear) begin
			smoothed_load_q  <= '0;
			smoothed_loss_q  <= '0;
			awaiting_first_q <= 1'b1;
		end else if (sm_update) begin
			smoothed_load_q  <= ema_load;
			smoothed_loss_q  <= ema_loss;
			awaiting_first_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q.load_estimate  <= smoothed_load_q;
			out_word_q.loss_estimate  <= smoothed_loss_q;
			out_word_q.estimate_valid <= !awaiting_first_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// an accepted word always starts the prepare cycle
	a_take_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_PREP)
		else $error("accepted word did not enter prepare");

	// averages stay cleared until seeded
	a_unseeded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_first_q |-> (smoothed_load_q == '0) && (smoothed_loss_q == '0))
		else $error("average nonzero before seeding");

	// loss ratio never exceeds one
	a_loss_range: assert property (@(posedge clk) disable iff (!arst_n)
		smoothed_loss_q <= ONE_Q16)
		else $error("loss estimate above one");

	// averaging starts only after all quotient bits are out
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMA_START |-> $past(state_q) == ST_DIV && $past(cnt_q) == '0)
		else $error("averaging started before division finished");

endmodule

// File: bench/tb_aloha_load_ema_estimator.sv
`timescale 1ns / 1ps

import aema_pkg::*;

// Tracks the smoothed estimates the block should report and checks output words
class estimate_scoreboard;
	localparam int unsigned SLOT_CAP = 1024;

	logic [ALPHA_W-1:0]  alpha_load_q;
	logic [ALPHA_W-1:0]  alpha_loss_q;
	logic [WEIGHT_W-1:0] coll_weight_q;
	logic [LOAD_W-1:0]   load_avg;
	logic [LOSS_W-1:0]   loss_avg;
	bit                  seeding;
	out_word_t           pending_estimates[$];
	int                  errors;

	function new();
		alpha_load_q  = 17'd6554;
		alpha_loss_q  = 17'd6554;
		coll_weight_q = 16'd256;
		load_avg      = '0;
		loss_avg      = '0;
		seeding       = 1'b1;
		errors        = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_ALPHA_LOAD:  alpha_load_q = data[ALPHA_W-1:0];
			REG_ALPHA_LOSS:  alpha_loss_q = data[ALPHA_W-1:0];
			REG_COLL_WEIGHT: coll_weight_q = data[WEIGHT_W-1:0];
			default: ;
		endcase
	endfunction

	static function longint unsigned clip_slots(logic [SLOT_W-1:0] v);
		return (v > SLOT_CAP) ? SLOT_CAP : longint'(v);
	endfunction

	// one averaging step, alpha above 1.0 acts as 1.0
	static function longint unsigned blend(logic [ALPHA_W-1:0] alpha, longint unsigned inst,
			longint unsigned old);
		longint unsigned a;
		a = (alpha > ONE_Q16) ? longint'(ONE_Q16) : longint'(alpha);
		return (a * inst + (65536 - a) * old + 32768) >> 16;
	endfunction

	// advance the estimates by one accepted input word and queue the expected output
	function void predict_estimates(in_word_t w);
		longint unsigned tot, suc, col, num, att, inst_load, inst_loss;
		out_word_t want;
		tot = clip_slots(w.total_slots);
		suc = clip_slots(w.success_slots);
		col = clip_slots(w.collision_slots);
		if (w.req_type == REQ_RESTART) begin
			load_avg = '0;
			loss_avg = '0;
			seeding  = 1'b1;
		end else if (tot != 0) begin
			num = suc * 256 + col * coll_weight_q;
			inst_load = (num * 256 + tot / 2) / tot;
			if (inst_load > LOAD_MAX)
				inst_load = LOAD_MAX;
			att = suc + col;
			inst_loss = 0;
			if (att != 0)
				inst_loss = (col * 65536 + att / 2) / att;
			if (seeding) begin
				load_avg = LOAD_W'(inst_load);
				loss_avg = LOSS_W'(inst_loss);
				seeding  = 1'b0;
			end else begin
				load_avg = LOAD_W'(blend(alpha_load_q, inst_load, load_avg));
				loss_avg = LOSS_W'(blend(alpha_loss_q, inst_loss, loss_avg));
			end
		end
		want.load_estimate  = load_avg;
		want.loss_estimate  = loss_avg;
		want.estimate_valid = !seeding;
		pending_estimates.push_back(want);
	endfunction

	// compare one accepted output word with the oldest expectation
	function void check_word(out_word_t got);
		out_word_t want;
		if (pending_estimates.size() == 0) begin
			$error("output word with no expectation: load %0d loss %0d valid %0d",
				got.load_estimate, got.loss_estimate, got.estimate_valid);
			errors++;
			return;
		end
		want = pending_estimates.pop_front();
		if (got.load_estimate !== want.load_estimate) begin
			$error("load_estimate: expected %0d, got %0d", want.load_estimate,
				got.load_estimate);
			errors++;
		end
		if (got.loss_estimate !== want.loss_estimate) begin
			$error("loss_estimate: expected %0d, got %0d", want.loss_estimate,
				got.loss_estimate);
			errors++;
		end
		if (got.estimate_valid !== want.estimate_valid) begin
			$error("estimate_valid: expected %0d, got %0d", want.estimate_valid,
				got.estimate_valid);
			errors++;
		end
	endfunction

	function int pending();
		return pending_estimates.size();
	endfunction
endclass

module tb_aloha_load_ema_estimator;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned SEGMENTS     = 12;
	localparam int unsigned SEG_WORDS    = 108;
	localparam int unsigned SETTLE       = 50;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_word_t             in_word   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_word;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	estimate_scoreboard sb = new();
	int unsigned cycles = 0;
	int unsigned tx_idle_pct = 30;
	int unsigned rx_idle_pct = 69;

	aloha_load_ema_estimator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("aloha_load_ema_estimator verification failed");
			$finish;
		end
	end

	// take output words and pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(out_word);
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	function automatic in_word_t mk_word(logic req, int unsigned tot, int unsigned suc,
			int unsigned col);
		in_word_t w;
		w.req_type        = req;
		w.total_slots     = SLOT_W'(tot);
		w.success_slots   = SLOT_W'(suc);
		w.collision_slots = SLOT_W'(col);
		return w;
	endfunction

	// mostly consistent frames, some restarts, empty frames and raw noise
	function automatic in_word_t random_word();
		int unsigned r, tot, suc, col;
		r = $urandom_range(99);
		if (r < 5)
			return mk_word(REQ_RESTART, $urandom_range(2047), $urandom_range(2047),
				$urandom_range(2047));
		if (r < 10)
			return mk_word(REQ_REPORT, 0, $urandom_range(2047), $urandom_range(2047));
		if (r < 20)
			return mk_word(REQ_REPORT, $urandom_range(2047), $urandom_range(2047),
				$urandom_range(2047));
		tot = ($urandom_range(3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 16);
		suc = $urandom_range(0, tot);
		col = $urandom_range(0, tot - suc);
		return mk_word(REQ_REPORT, tot, suc, col);
	endfunction

	function automatic logic [CFG_W-1:0] random_alpha();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return ONE_Q16;
		if (r == 2)
			return CFG_W'($urandom_range(65537, 131071));
		return CFG_W'($urandom_range(1, 65535));
	endfunction

	// present one word, hold it until accepted
	task automatic send_word(in_word_t w);
		int unsigned gap;
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do
			@(posedge clk);
		while (in_stall);
		sb.predict_estimates(w);
	endtask

	// drop valid and wait for every expected word to come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers back to back, optionally the unused index too
	task automatic program_regs(logic [CFG_W-1:0] a_load, logic [CFG_W-1:0] a_loss,
			logic [CFG_W-1:0] weight, bit spare);
		cfg_write <= 1'b1;
		cfg_index <= REG_ALPHA_LOAD;
		cfg_data  <= a_load;
		@(posedge clk);
		sb.set_reg(REG_ALPHA_LOAD, a_load);
		cfg_index <= REG_ALPHA_LOSS;
		cfg_data  <= a_loss;
		@(posedge clk);
		sb.set_reg(REG_ALPHA_LOSS, a_loss);
		cfg_index <= REG_COLL_WEIGHT;
		cfg_data  <= weight;
		@(posedge clk);
		sb.set_reg(REG_COLL_WEIGHT, weight);
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_data  <= CFG_W'($urandom);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		in_word_t directed[$];
		int unsigned seg;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame before seeding, then seed and edge counts under reset registers
		directed.push_back(mk_word(REQ_REPORT, 0, 5, 5));
		directed.push_back(mk_word(REQ_REPORT, 10, 4, 3));
		directed.push_back(mk_word(REQ_REPORT, 1, 0, 0));
		directed.push_back(mk_word(REQ_REPORT, 1024, 1024, 0));
		directed.push_back(mk_word(REQ_REPORT, 1024, 0, 1024));
		directed.push_back(mk_word(REQ_REPORT, 1, 1024, 1024));
		directed.push_back(mk_word(REQ_REPORT, 2047, 2047, 2047));
		directed.push_back(mk_word(REQ_REPORT, 1025, 1030, 1500));
		directed.push_back(mk_word(REQ_REPORT, 0, 2047, 2047));
		directed.push_back(mk_word(REQ_RESTART, 0, 0, 0));
		directed.push_back(mk_word(REQ_REPORT, 0, 1, 1));
		directed.push_back(mk_word(REQ_REPORT, 7, 0, 0));
		directed.push_back(mk_word(REQ_REPORT, 3, 1, 1));
		directed.push_back(mk_word(REQ_RESTART, 2047, 2047, 2047));
		directed.push_back(mk_word(REQ_REPORT, 1024, 512, 512));
		directed.push_back(mk_word(REQ_REPORT, 2, 1, 1));
		foreach (directed[k])
			send_word(directed[k]);
		drain();

		// extreme weight saturates the load, zero weight and alpha freeze it
		program_regs(ONE_Q16, ONE_Q16, 17'h1FFFF, 1'b1);
		send_word(mk_word(REQ_REPORT, 1, 1024, 1024));
		send_word(mk_word(REQ_REPORT, 1024, 1, 1));
		send_word(mk_word(REQ_REPORT, 3, 0, 3));
		drain();
		program_regs('0, '0, '0, 1'b0);
		send_word(mk_word(REQ_REPORT, 9, 0, 9));
		send_word(mk_word(REQ_REPORT, 1024, 1024, 0));
		drain();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			// sender idles lightly and receiver heavily first, then the reverse, then nobody idles
			if (seg < 4) begin
				tx_idle_pct = 30;
				rx_idle_pct = 69;
			end else if (seg < 8) begin
				tx_idle_pct = 69;
				rx_idle_pct = 30;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (seg)
				0: program_regs(ONE_Q16, ONE_Q16, 17'd65535, 1'b0);
				1: program_regs('0, '0, '0, 1'b0);
				2: program_regs(17'h1FFFF, 17'd100000, 17'd256, 1'b0);
				4: program_regs(17'd1, 17'd65535, 17'd1, 1'b1);
				6: program_regs(17'd6554, 17'd6554, 17'd256, 1'b0);
				default: program_regs(random_alpha(), random_alpha(), CFG_W'($urandom),
					1'($urandom_range(1)));
			endcase
			repeat (SEG_WORDS)
				send_word(random_word());
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("aloha_load_ema_estimator verification clean");
		else
			$display("aloha_load_ema_estimator verification failed");
		$finish;
	end

endmodule
